// ----- design/ssmd_pkg.sv -----
// Package for the seven-segment message driver.
// Holds the digit count, payload structs, cell data type and the segment font.
// No dependencies.
`default_nettype none

package ssmd_pkg;

  // Number of display digits, and therefore of segment bytes per request.
  localparam int unsigned DIGITS = 5;

  localparam int unsigned CodeW  = 6;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SlotsW = DIGITS * CodeW;
  localparam int unsigned IdxW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned PosW   = 3;
  localparam int unsigned QuotW  = 29;

  // Exact division by ten for any 32-bit value: (x * RecipTen) >> RecipShift.
  localparam logic [ValW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned     RecipShift = 35;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(DIGITS - 1);

  typedef logic [CodeW-1:0] code_t;

  typedef enum logic {
    OP_CODES  = 1'b0,
    OP_NUMBER = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [29:0] codes;
    logic [31:0] number;
  } ssmd_in_t;

  typedef struct packed {
    logic [7:0]      segments;
    logic [PosW-1:0] position;
    logic            last;
  } ssmd_out_t;

  // What travels from cell to cell: the mode, the value still to be taken
  // apart, and the character codes collected so far.
  typedef struct packed {
    logic              op;
    logic [ValW-1:0]   value;
    logic [SlotsW-1:0] slots;
  } cell_data_t;

  // Segment font, bit 0 = a through bit 6 = g. Codes past the font are blank.
  function automatic logic [7:0] glyph_of(code_t code);
    logic [7:0] seg;
    unique case (code)
      6'd0:  seg = 8'h3F;
      6'd1:  seg = 8'h06;
      6'd2:  seg = 8'h5B;
      6'd3:  seg = 8'h4F;
      6'd4:  seg = 8'h66;
      6'd5:  seg = 8'h6D;
      6'd6:  seg = 8'h7D;
      6'd7:  seg = 8'h07;
      6'd8:  seg = 8'h7F;
      6'd9:  seg = 8'h6F;
      6'd11: seg = 8'h40;
      6'd16: seg = 8'h77;
      6'd17: seg = 8'h7C;
      6'd18: seg = 8'h39;
      6'd19: seg = 8'h5E;
      6'd20: seg = 8'h79;
      6'd21: seg = 8'h71;
      6'd22: seg = 8'h3D;
      6'd23: seg = 8'h76;
      6'd24: seg = 8'h30;
      6'd25: seg = 8'h0E;
      6'd26: seg = 8'h7A;
      6'd27: seg = 8'h38;
      6'd29: seg = 8'h54;
      6'd30: seg = 8'h3F;
      6'd31: seg = 8'h73;
      6'd33: seg = 8'h50;
      6'd34: seg = 8'h6D;
      6'd35: seg = 8'h78;
      6'd36: seg = 8'h3E;
      6'd40: seg = 8'h72;
      6'd41: seg = 8'h5B;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ----- design/ssmd_cell.sv -----
// One cell of the digit extraction chain.
// Depends on ssmd_pkg for the cell data type and the reciprocal constant.
`default_nettype none

module ssmd_cell import ssmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cell_data_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cell_data_t out_data_o
);

  logic                     valid_q;
  cell_data_t               data_q, data_d;
  logic [2*ValW-1:0]        prod;
  logic [QuotW-1:0]         quot;
  logic [ValW-1:0]          tenfold;
  logic [ValW-1:0]          diff;
  code_t                    code;
  logic [SlotsW+CodeW-1:0]  up_wide;
  logic [SlotsW+CodeW-1:0]  dn_wide;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    prod    = {{ValW{1'b0}}, in_data_i.value} * {{ValW{1'b0}}, RecipTen};
    quot    = prod[RecipShift +: QuotW];
    tenfold = ValW'({quot, 3'b000}) + ValW'({quot, 1'b0});
    diff    = in_data_i.value - tenfold;
    data_d.op = in_data_i.op;
    if (op_e'(in_data_i.op) == OP_NUMBER) begin
      code         = {2'b00, diff[3:0]};
      data_d.value = ValW'(quot);
    end else begin
      code         = in_data_i.value[CodeW-1:0];
      data_d.value = in_data_i.value >> CodeW;
    end
    // Character codes fill from the top so the first one lands in slot 0;
    // decimal digits come out units first, so they fill from the bottom.
    up_wide = {code, in_data_i.slots};
    dn_wide = {in_data_i.slots, code};
    if (op_e'(in_data_i.op) == OP_NUMBER) begin
      data_d.slots = dn_wide[SlotsW-1:0];
    end else begin
      data_d.slots = up_wide[SlotsW+CodeW-1:CodeW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/ssmd_serializer.sv -----
// Byte serializer: emits one font-mapped segment byte per transaction.
// Depends on ssmd_pkg for the cell data type, output struct and font.
`default_nettype none

module ssmd_serializer import ssmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cell_data_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ssmd_out_t  out_data_o
);

  logic              valid_q;
  logic [IdxW-1:0]   idx_q;
  logic [SlotsW-1:0] slots_q;
  logic              is_last;
  logic [IdxW+PosW-1:0] pos_wide;

  assign is_last     = (idx_q == LastIdx);
  assign in_ready_o  = !valid_q || (out_ready_i && is_last);
  assign out_valid_o = valid_q;
  assign pos_wide    = {{PosW{1'b0}}, idx_q};

  always_comb begin
    out_data_o.segments = glyph_of(slots_q[CodeW*idx_q +: CodeW]);
    out_data_o.position = pos_wide[PosW-1:0];
    out_data_o.last     = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
      idx_q   <= '0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      slots_q <= in_data_i.slots;
    end
  end

endmodule

`default_nettype wire

// ----- design/seven_segment_message_driver.sv -----
// Top level of the seven-segment message driver.
// Depends on ssmd_pkg, ssmd_cell and ssmd_serializer.
`default_nettype none

// Each request transaction turns into DIGITS segment-byte transactions (five
// in this build), given in the order they are shifted into the display chain,
// with last set on the final byte where the latch is to be pulsed. With op
// clear, the 30-bit codes word is read as six-bit character codes, lowest bits
// first, and every code from 42 up shows as a blank digit. With op set, the
// low DIGITS decimal digits of number are shown, most significant first, with
// leading zeros kept. A request walks through a row of DIGITS identical cells;
// every cell peels one code or one decimal digit (by a reciprocal multiply)
// off the value and passes the rest on. A serializer then hands out one byte
// per cycle while the output is ready; a request reaches the output once it
// has passed each cell register and the serializer register. Requests flow
// back to back through the cells; the serializer takes the next request as
// the last byte of the current one is taken, so the single output channel
// sets the sustained rate. Back-pressure on the output stalls the whole row.

module seven_segment_message_driver import ssmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ssmd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ssmd_out_t out_data_o
);

  // Handshake and data at the boundary in front of each cell; index DIGITS is
  // the serializer input.
  logic       chain_valid [DIGITS+1];
  logic       chain_ready [DIGITS+1];
  cell_data_t chain_data  [DIGITS+1];

  // In code mode the 30-bit word is widened with zeros, so any digit beyond the
  // fifth would show the pattern of code 0.
  always_comb begin
    chain_data[0].op    = in_data_i.op;
    chain_data[0].value = (op_e'(in_data_i.op) == OP_NUMBER) ?
                          in_data_i.number : ValW'(in_data_i.codes);
    chain_data[0].slots = '0;
  end

  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  for (genvar g = 0; g < DIGITS; g++) begin : g_cell
    ssmd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_data_i   (chain_data[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_data_o  (chain_data[g+1])
    );
  end

  ssmd_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[DIGITS]),
    .in_ready_o  (chain_ready[DIGITS]),
    .in_data_i   (chain_data[DIGITS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Within a request, each byte taken is followed by the next position.
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_valid_o && (out_data_o.position == $past(out_data_o.position) + 3'd1))
    else $error("segment byte position did not advance");

  // A new request always starts at position zero.
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=>
      !out_valid_o || (out_data_o.position == '0))
    else $error("request did not start at position zero");

  // The dot segment is never lit by the font.
  a_no_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.segments[7])
    else $error("dot segment set");

endmodule

`default_nettype wire
